// ----- src/edisp_pkg.sv -----
// package: shared types, codes and constants of the ethertype frame id dispatcher
package edisp_pkg;

  localparam int MAP_ENTRIES_DEFAULT     = 16;
  localparam int MAX_FRAME_BYTES_DEFAULT = 2048;

  localparam logic [15:0] TYPE_VLAN = 16'h8100;
  localparam logic [15:0] TYPE_RT   = 16'h8892;
  localparam logic [15:0] TYPE_LLDP = 16'h88CC;
  localparam logic [15:0] TYPE_IP   = 16'h0800;

  localparam logic [10:0] TYPE_POS_RESET = 11'd12;
  localparam logic [11:0] VLAN_TAG_BYTES = 12'd4;
  localparam logic [11:0] OFFSET_MAX     = 12'd2047;

  typedef enum logic [1:0] {
    KIND_BYTE   = 2'd0,
    KIND_ADD    = 2'd1,
    KIND_REMOVE = 2'd2
  } kind_t;

  typedef enum logic [3:0] {
    ST_MATCHED    = 4'd0,
    ST_NO_HANDLER = 4'd1,
    ST_LLDP       = 4'd2,
    ST_IP         = 4'd3,
    ST_OTHER      = 4'd4,
    ST_TRUNCATED  = 4'd5,
    ST_ADDED      = 4'd6,
    ST_FULL       = 4'd7,
    ST_REMOVED    = 4'd8,
    ST_NOT_FOUND  = 4'd9
  } status_t;

  typedef enum logic [2:0] {
    PH_HEADER = 3'b001,
    PH_ID     = 3'b010,
    PH_DONE   = 3'b100
  } phase_t;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_FIN  = 5'b00010,
    S_READ = 5'b00100,
    S_CMP  = 5'b01000,
    S_EMIT = 5'b10000
  } ctl_state_t;

  // controller to datapath
  typedef struct packed {
    logic take_byte;
    logic load;
    logic rd_en;
    logic check;
    logic inc_scan;
    logic commit;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_scan;
    logic match;
    logic scan_last;
    logic out_free;
  } dp_sts_t;

endpackage

// ----- src/edisp_if.sv -----
// interfaces: input item channel and result channel
interface edisp_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  data_byte;
  logic        last_byte;
  logic [15:0] entry_frame_id;
  logic [7:0]  handler_tag;

  modport source (output valid, kind, data_byte, last_byte, entry_frame_id, handler_tag,
                  input ready);
  modport sink (input valid, kind, data_byte, last_byte, entry_frame_id, handler_tag,
                output ready);
endinterface

interface edisp_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  status;
  logic [3:0]  slot;
  logic [15:0] id_out;
  logic [7:0]  tag_out;
  logic [10:0] payload_offset;
  logic [15:0] ether_type;

  modport source (output valid, status, slot, id_out, tag_out, payload_offset, ether_type,
                  input ready);
  modport sink (input valid, status, slot, id_out, tag_out, payload_offset, ether_type,
                output ready);
endinterface

// ----- src/edisp_ram.sv -----
// generic ram: one write port, one read port with registered read data
module edisp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- src/edisp_ctl.sv -----
// controller: sequences byte intake, slot table scan and result delivery
module edisp_ctl
  import edisp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [1:0] in_kind,
  input  logic       in_last,
  output logic       in_ready,
  output dp_cmd_t    cmd,
  input  dp_sts_t    sts
);

  ctl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_kind == KIND_BYTE) begin
            cmd.take_byte = 1'b1;
            if (in_last) begin
              cmd.load   = 1'b1;
              state_next = S_FIN;
            end
          end else if (in_kind == KIND_ADD || in_kind == KIND_REMOVE) begin
            cmd.load   = 1'b1;
            state_next = S_READ;
          end
        end
      end
      S_FIN: begin
        state_next = sts.need_scan ? S_READ : S_EMIT;
      end
      S_READ: begin
        cmd.rd_en  = 1'b1;
        state_next = S_CMP;
      end
      S_CMP: begin
        cmd.check = 1'b1;
        if (sts.match || sts.scan_last) begin
          state_next = S_EMIT;
        end else begin
          cmd.inc_scan = 1'b1;
          state_next   = S_READ;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  a_read_then_cmp: assert property (@(posedge clk) disable iff (rst)
    state == S_READ |=> state == S_CMP)
    else $error("table read not followed by compare");

  a_emit_returns_idle: assert property (@(posedge clk) disable iff (rst)
    state == S_EMIT && sts.out_free |=> state == S_IDLE && !cmd.commit)
    else $error("result delivery did not return to idle");

endmodule

// ----- src/edisp_dp.sv -----
// datapath: header parse, slot table with scan, result build and output register
module edisp_dp
  import edisp_pkg::*;
#(
  parameter int MAP_ENTRIES     = MAP_ENTRIES_DEFAULT,
  parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  logic [1:0]     kind,
  input  logic [7:0]     data_byte,
  input  logic [15:0]    entry_frame_id,
  input  logic [7:0]     handler_tag,
  input  dp_cmd_t        cmd,
  output dp_sts_t        sts,
  edisp_out_if.source    rsp
);

  localparam int IDX_W     = (MAP_ENTRIES > 1) ? $clog2(MAP_ENTRIES) : 1;
  localparam int POS_LIMIT = (MAX_FRAME_BYTES > 2048) ? 2048 : MAX_FRAME_BYTES;
  localparam int POS_W     = $clog2(POS_LIMIT + 1);

  // parse state
  logic [POS_W-1:0] byte_position;
  logic [10:0]      type_field_position;
  logic [15:0]      word_shift;
  logic [15:0]      found_type;
  logic [15:0]      found_id;
  phase_t           parse_phase;

  // latched item
  logic [1:0]       op_kind;
  logic [15:0]      op_fid;
  logic [7:0]       op_tag;

  // table scan
  logic [MAP_ENTRIES-1:0] entry_valid;
  logic [IDX_W-1:0]       scan_idx;
  logic                   hit;
  logic [IDX_W-1:0]       hit_slot;
  logic [7:0]             hit_tag;
  logic [23:0]            rd_data;

  // output register
  logic                   out_valid;
  status_t                res_status;
  logic [3:0]             res_slot;
  logic [15:0]            res_fid;
  logic [7:0]             res_tag;
  logic [10:0]            res_off;
  logic [15:0]            res_type;

  logic [15:0]            ws_next;
  logic [12:0]            pos_ext;
  logic [11:0]            tfp_vlan;
  logic [11:0]            off_sum;
  logic [10:0]            off_sat;
  logic [15:0]            key;
  logic                   slot_match;
  logic                   table_we;
  logic                   op_frame;

  assign ws_next  = {word_shift[7:0], data_byte};
  assign pos_ext  = 13'(byte_position);
  assign tfp_vlan = 12'(type_field_position) + VLAN_TAG_BYTES;
  assign off_sum  = 12'(type_field_position) + 12'd2;
  assign off_sat  = (off_sum > OFFSET_MAX) ? OFFSET_MAX[10:0] : off_sum[10:0];
  assign op_frame = (op_kind == KIND_BYTE);
  assign key      = op_frame ? found_id : op_fid;

  // add looks for a free slot, lookup and remove for a valid equal id
  always_comb begin
    if (op_kind == KIND_ADD) begin
      slot_match = !entry_valid[scan_idx];
    end else begin
      slot_match = entry_valid[scan_idx] && (rd_data[23:8] == key);
    end
  end

  assign sts.need_scan = (parse_phase == PH_DONE) && (found_type == TYPE_RT);
  assign sts.match     = slot_match;
  assign sts.scan_last = (scan_idx == IDX_W'(MAP_ENTRIES - 1));
  assign sts.out_free  = !out_valid || rsp.ready;

  assign table_we = cmd.commit && hit && (op_kind == KIND_ADD);

  edisp_ram #(
    .WIDTH (24),
    .DEPTH (MAP_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (table_we),
    .waddr (hit_slot),
    .wdata ({op_fid, op_tag}),
    .re    (cmd.rd_en),
    .raddr (scan_idx),
    .rdata (rd_data)
  );

  // header parse, one byte per beat
  always_ff @(posedge clk) begin
    if (rst || (cmd.commit && op_frame)) begin
      byte_position       <= '0;
      type_field_position <= TYPE_POS_RESET;
      word_shift          <= '0;
      found_type          <= '0;
      found_id            <= '0;
      parse_phase         <= PH_HEADER;
    end else if (cmd.take_byte && (byte_position < POS_W'(POS_LIMIT))) begin
      word_shift    <= ws_next;
      byte_position <= byte_position + POS_W'(1);
      if (parse_phase == PH_HEADER && pos_ext == 13'(type_field_position) + 13'd1) begin
        if (ws_next == TYPE_VLAN) begin
          type_field_position <= (tfp_vlan > OFFSET_MAX) ? OFFSET_MAX[10:0] : tfp_vlan[10:0];
        end else begin
          found_type  <= ws_next;
          parse_phase <= (ws_next == TYPE_RT) ? PH_ID : PH_DONE;
        end
      end else if (parse_phase == PH_ID && pos_ext == 13'(type_field_position) + 13'd3) begin
        found_id    <= ws_next;
        parse_phase <= PH_DONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_kind <= kind;
      op_fid  <= entry_frame_id;
      op_tag  <= handler_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      scan_idx <= '0;
    end else if (cmd.inc_scan) begin
      scan_idx <= scan_idx + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit <= 1'b0;
    end else if (cmd.load) begin
      hit <= 1'b0;
    end else if (cmd.check && slot_match) begin
      hit <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.check && slot_match) begin
      hit_slot <= scan_idx;
      hit_tag  <= rd_data[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (cmd.commit && hit) begin
      if (op_kind == KIND_ADD) begin
        entry_valid[hit_slot] <= 1'b1;
      end else if (op_kind == KIND_REMOVE) begin
        entry_valid[hit_slot] <= 1'b0;
      end
    end
  end

  // result build
  always_comb begin
    res_status = ST_OTHER;
    res_slot   = '0;
    res_fid    = '0;
    res_tag    = '0;
    res_off    = '0;
    res_type   = '0;
    priority if (op_kind == KIND_ADD) begin
      res_fid = op_fid;
      if (hit) begin
        res_status = ST_ADDED;
        res_slot   = 4'(hit_slot);
        res_tag    = op_tag;
      end else begin
        res_status = ST_FULL;
      end
    end else if (op_kind == KIND_REMOVE) begin
      res_fid = op_fid;
      if (hit) begin
        res_status = ST_REMOVED;
        res_slot   = 4'(hit_slot);
        res_tag    = hit_tag;
      end else begin
        res_status = ST_NOT_FOUND;
      end
    end else begin
      unique case (parse_phase)
        PH_HEADER: begin
          res_status = ST_TRUNCATED;
        end
        PH_ID: begin
          res_status = ST_TRUNCATED;
          res_off    = off_sat;
          res_type   = found_type;
        end
        PH_DONE: begin
          res_off  = off_sat;
          res_type = found_type;
          if (found_type == TYPE_RT) begin
            res_fid = found_id;
            if (hit) begin
              res_status = ST_MATCHED;
              res_slot   = 4'(hit_slot);
              res_tag    = hit_tag;
            end else begin
              res_status = ST_NO_HANDLER;
            end
          end else if (found_type == TYPE_LLDP) begin
            res_status = ST_LLDP;
          end else if (found_type == TYPE_IP) begin
            res_status = ST_IP;
          end else begin
            res_status = ST_OTHER;
          end
        end
        default: begin
          res_status = ST_TRUNCATED;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      rsp.status         <= res_status;
      rsp.slot           <= res_slot;
      rsp.id_out         <= res_fid;
      rsp.tag_out        <= res_tag;
      rsp.payload_offset <= res_off;
      rsp.ether_type     <= res_type;
    end
  end

  assign rsp.valid = out_valid;

  a_commit_needs_room: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> sts.out_free)
    else $error("result loaded over a beat not yet taken");

  a_frame_end_clears_parse: assert property (@(posedge clk) disable iff (rst)
    cmd.commit && op_frame |=> byte_position == '0 && parse_phase == PH_HEADER)
    else $error("parse state not cleared after frame result");

endmodule

// ----- src/ethertype_frame_id_dispatcher.sv -----
// top level: ethertype classifier and frame id dispatcher
// Frame bytes enter on req one beat per cycle while ready is high, from the destination
// MAC on; both MAC addresses and any chain of 802.1Q tags are skipped, and the ethertype
// that follows is reported on rsp when the beat with last_byte set arrives. For the
// real-time ethertype 0x8892 the next two bytes are the frame id, looked up in a table
// of MAP_ENTRIES slots where the lowest valid matching slot wins. Add and remove beats
// edit that table and report at once; kind 3 is taken and dropped. A non-last frame beat
// leaves the controller in S_IDLE. The last beat of a frame passes S_FIN, then for a
// real-time frame id S_READ and S_CMP per slot until a match or the last slot, then
// S_EMIT; an add or remove runs that scan and S_EMIT. The slot table is one memory with
// a single registered read port, scanned one slot per read and compare pair. A finished
// result sits in an output register, and frame beats keep flowing while it waits.
module ethertype_frame_id_dispatcher
  import edisp_pkg::*;
#(
  parameter int MAP_ENTRIES     = MAP_ENTRIES_DEFAULT,
  parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  edisp_in_if.sink     req,
  edisp_out_if.source  rsp
);

  // command and status between controller and datapath
  dp_cmd_t cmd;
  dp_sts_t sts;
  logic    in_ready;

  assign req.ready = in_ready;

  // controller decides when a beat is taken and when the result is loaded
  edisp_ctl u_ctl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_kind  (req.kind),
    .in_last  (req.last_byte),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  // datapath holds parse state, the slot table and the output register
  edisp_dp #(
    .MAP_ENTRIES     (MAP_ENTRIES),
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .kind           (req.kind),
    .data_byte      (req.data_byte),
    .entry_frame_id (req.entry_frame_id),
    .handler_tag    (req.handler_tag),
    .cmd            (cmd),
    .sts            (sts),
    .rsp            (rsp)
  );

endmodule
